[rtl/wvsd_pkg.sv]
// Shared types and constants for the windowed variance stability detector.
// No dependencies; every other file in rtl/ except wvsd_ram refers to this package.
package wvsd_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int THR_W       = 26;
  localparam int SCORE_OUT_W = 29;
  localparam int NUM_AXES    = 3;
  localparam int RAM_W       = NUM_AXES * SAMPLE_W;

  localparam logic [THR_W-1:0]       THR_RESET     = 26'd2560;
  localparam logic [SCORE_OUT_W-1:0] SCORE_OUT_MAX = 29'h1FFF_FFFF;

  // Multiplier operations of the datapath.
  typedef enum logic [1:0] {
    OP_DELTA = 2'd0,  // (new - old) * (new + old) into the square sum
    OP_SSQ   = 2'd1,  // sum * sum
    OP_WSQ   = 2'd2   // WINDOW * square sum, then accumulate the axis spread
  } op_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;      // request accepted: latch samples, read old entry
    logic  load;         // latch old entry, write new one, advance slot
    logic  mul_en;       // run one multiplier step
    op_t   op;
    axis_t axis;
    logic  clear_score;
    logic  finish;       // register the result into the output stage
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

[rtl/wvsd_if.sv]
// Request channel interfaces: sample requests in, result requests out.
// Depends on wvsd_pkg for field widths.
interface wvsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [wvsd_pkg::SAMPLE_W-1:0] sample_x;
  logic [wvsd_pkg::SAMPLE_W-1:0] sample_y;
  logic [wvsd_pkg::SAMPLE_W-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

interface wvsd_out_if;
  logic                             valid;
  logic                             ready;
  logic                             is_stable;
  logic [wvsd_pkg::SCORE_OUT_W-1:0] variance_score;

  modport source (output valid, output is_stable, output variance_score, input ready);
  modport sink   (input valid, input is_stable, input variance_score, output ready);
endinterface

[rtl/windowed_variance_stability_detector.sv]
// Windowed variance stability detector, top level. Depends on wvsd_pkg, the channel
// interfaces, wvsd_ctrl and wvsd_dp.
//
// Each accepted request carries one three-axis 10-bit sample, which replaces the oldest
// entry of a WINDOW-deep ring window that starts out all zero and is always averaged
// as full. The result reports variance_score = sum over axes of N*sum(x^2) - (sum x)^2
// (N = WINDOW), saturated at 2^29-1, and is_stable when 256*score < 3*N*N*threshold,
// the threshold being the last value written on cfg_max_variance_q8 (reset 2560, i.e.
// 10.0 in Q8). A new request is taken only when the previous item is finished: the
// outgoing window entry is read from RAM on acceptance, then loaded while the new
// sample is written, then nine steps of the single shared multiplier run (three per
// axis), and the result is registered once the output register is free. A finished
// result waits in the output register while the next request is already processed.
// A threshold write reaches thr_r, then the registered rhs_r used at the compare.
module windowed_variance_stability_detector #(
  parameter int WINDOW = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wvsd_in_if.sink                    in_chan,
  wvsd_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [wvsd_pkg::THR_W-1:0] cfg_max_variance_q8
);

  wvsd_pkg::cmd_t    cmd;
  wvsd_pkg::status_t status;
  logic              in_ready;

  wvsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wvsd_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .sample_x      (in_chan.sample_x),
    .sample_y      (in_chan.sample_y),
    .sample_z      (in_chan.sample_z),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_max_variance_q8),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .out_is_stable (out_chan.is_stable),
    .out_score     (out_chan.variance_score)
  );

  assign in_chan.ready = in_ready;

  // A request is never followed by another in the next cycle.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request accepted while the previous one is still in work");

  // The output register is only loaded when it is empty or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten before it was taken");

  // A result appears only after the controller finished an item.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.finish))
    else $error("result valid without a finished item");

  // The multiplier never runs in the cycle a request is captured.
  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> !cmd.mul_en && !cmd.load)
    else $error("capture overlaps datapath work");

endmodule

[rtl/wvsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wvsd_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/wvsd_ctrl.sv]
// Controller state machine: sequences capture, load, the nine multiplier steps and finish.
// Depends on wvsd_pkg for the command and status types.
module wvsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wvsd_pkg::status_t status,
  output wvsd_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_CALC = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  wvsd_pkg::op_t   op_r, op_nxt;
  wvsd_pkg::axis_t axis_r, axis_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and step counters.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    axis_nxt  = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_CALC;
        op_nxt    = wvsd_pkg::OP_DELTA;
        axis_nxt  = wvsd_pkg::AXIS_X;
      end
      ST_CALC: begin
        case (op_r)
          wvsd_pkg::OP_DELTA: op_nxt = wvsd_pkg::OP_SSQ;
          wvsd_pkg::OP_SSQ:   op_nxt = wvsd_pkg::OP_WSQ;
          default: begin
            op_nxt = wvsd_pkg::OP_DELTA;
            case (axis_r)
              wvsd_pkg::AXIS_X: axis_nxt = wvsd_pkg::AXIS_Y;
              wvsd_pkg::AXIS_Y: axis_nxt = wvsd_pkg::AXIS_Z;
              default:          state_nxt = ST_DONE;
            endcase
          end
        endcase
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd             = '0;
    cmd.capture     = (state_r == ST_IDLE) && in_valid;
    cmd.load        = (state_r == ST_LOAD);
    cmd.clear_score = (state_r == ST_LOAD);
    cmd.mul_en      = (state_r == ST_CALC);
    cmd.op          = op_r;
    cmd.axis        = axis_r;
    cmd.finish      = (state_r == ST_DONE) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= wvsd_pkg::OP_DELTA;
      axis_r  <= wvsd_pkg::AXIS_X;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

[rtl/wvsd_dp.sv]
// Datapath: sample window RAM, running sums, shared multiplier, score and output stage.
// Depends on wvsd_pkg and wvsd_ram.
module wvsd_dp #(
  parameter int WINDOW = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wvsd_pkg::cmd_t                   cmd,
  output wvsd_pkg::status_t                status,
  input  logic [wvsd_pkg::SAMPLE_W-1:0]    sample_x,
  input  logic [wvsd_pkg::SAMPLE_W-1:0]    sample_y,
  input  logic [wvsd_pkg::SAMPLE_W-1:0]    sample_z,
  input  logic                             cfg_we,
  input  logic [wvsd_pkg::THR_W-1:0]       cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_is_stable,
  output logic [wvsd_pkg::SCORE_OUT_W-1:0] out_score
);

  localparam int SW      = wvsd_pkg::SAMPLE_W;
  localparam int NA      = wvsd_pkg::NUM_AXES;
  localparam int LOG_W   = $clog2(WINDOW);
  localparam int SUM_W   = LOG_W + SW;
  localparam int SQ_W    = LOG_W + 2 * SW;
  localparam int SCORE_W = 2 * LOG_W + 2 * SW;
  localparam int CMP_W   = SCORE_W + 8;
  localparam int K_W     = $clog2(3 * WINDOW * WINDOW + 1);
  localparam int RP_W    = wvsd_pkg::THR_W + K_W;
  localparam int OPA_W   = SQ_W + 1;
  localparam int OPB_W   = SUM_W + 1;
  localparam int PROD_W  = OPA_W + OPB_W;
  localparam int SAT_W   = (SCORE_W > wvsd_pkg::SCORE_OUT_W) ? SCORE_W : wvsd_pkg::SCORE_OUT_W;

  localparam logic [LOG_W-1:0] SLOT_LAST = LOG_W'(WINDOW - 1);
  localparam logic [K_W-1:0]   THR_SCALE = K_W'(3 * WINDOW * WINDOW);

  // Window slot and per-entry valid bits; an entry never written reads as zero.
  logic [LOG_W-1:0]  slot_r, slot_nxt;
  logic [WINDOW-1:0] valid_r, valid_nxt;

  logic [SW-1:0]      new_r [NA];
  logic [SW-1:0]      old_r [NA];
  logic [SUM_W-1:0]   sum_r [NA];
  logic [SUM_W-1:0]   sum_nxt [NA];
  logic [SQ_W-1:0]    sq_r [NA];
  logic [SQ_W-1:0]    sq_nxt [NA];
  logic [SCORE_W-1:0] tmp_r, tmp_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;

  logic [wvsd_pkg::THR_W-1:0] thr_r;
  logic [CMP_W-1:0]           rhs_r;
  logic [RP_W-1:0]            rhs_prod;

  logic                             out_valid_r, out_valid_nxt;
  logic                             out_stable_r;
  logic [wvsd_pkg::SCORE_OUT_W-1:0] out_score_r;

  logic [wvsd_pkg::RAM_W-1:0] ram_rdata;
  logic [SW-1:0]              rd_old [NA];

  logic [SW-1:0]            sel_new, sel_old;
  logic [SUM_W-1:0]         sel_sum;
  logic [SQ_W-1:0]          sel_sq;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SW:0]       diff;
  logic [SW:0]              pair_sum;

  logic [CMP_W-1:0]                 lhs;
  logic [SAT_W-1:0]                 score_ext;
  logic [wvsd_pkg::SCORE_OUT_W-1:0] score_sat;

  wvsd_ram #(
    .WIDTH (wvsd_pkg::RAM_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (slot_r),
    .wdata ({new_r[2], new_r[1], new_r[0]}),
    .re    (cmd.capture),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // Old entries leaving the window, zero where the slot was never written.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      rd_old[i] = valid_r[slot_r] ? ram_rdata[i*SW +: SW] : '0;
    end
  end

  // Slot advance and valid bits.
  always_comb begin
    slot_nxt  = slot_r;
    valid_nxt = valid_r;
    if (cmd.load) begin
      valid_nxt[slot_r] = 1'b1;
      slot_nxt          = (slot_r == SLOT_LAST) ? '0 : slot_r + LOG_W'(1);
    end
  end

  // Per-axis operand selection.
  always_comb begin
    sel_new = '0;
    sel_old = '0;
    sel_sum = '0;
    sel_sq  = '0;
    for (int i = 0; i < NA; i++) begin
      if (cmd.axis == wvsd_pkg::axis_t'(i)) begin
        sel_new = new_r[i];
        sel_old = old_r[i];
        sel_sum = sum_r[i];
        sel_sq  = sq_r[i];
      end
    end
  end

  // Shared multiplier.
  always_comb begin
    diff     = $signed({1'b0, sel_new}) - $signed({1'b0, sel_old});
    pair_sum = {1'b0, sel_new} + {1'b0, sel_old};
    case (cmd.op)
      wvsd_pkg::OP_DELTA: begin
        op_a = OPA_W'(diff);
        op_b = $signed(OPB_W'(pair_sum));
      end
      wvsd_pkg::OP_SSQ: begin
        op_a = $signed(OPA_W'(sel_sum));
        op_b = $signed(OPB_W'(sel_sum));
      end
      wvsd_pkg::OP_WSQ: begin
        op_a = $signed(OPA_W'(sel_sq));
        op_b = $signed(OPB_W'(WINDOW));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod = PROD_W'(op_a) * PROD_W'(op_b);
  end

  // Running sums, square sums and score accumulation.
  always_comb begin
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    tmp_nxt   = tmp_r;
    score_nxt = score_r;
    if (cmd.clear_score) begin
      score_nxt = '0;
    end
    if (cmd.mul_en) begin
      case (cmd.op)
        wvsd_pkg::OP_DELTA: begin
          for (int i = 0; i < NA; i++) begin
            if (cmd.axis == wvsd_pkg::axis_t'(i)) begin
              sum_nxt[i] = sum_r[i] + SUM_W'(sel_new) - SUM_W'(sel_old);
              sq_nxt[i]  = sq_r[i] + SQ_W'(prod);
            end
          end
        end
        wvsd_pkg::OP_SSQ: tmp_nxt   = SCORE_W'(prod);
        wvsd_pkg::OP_WSQ: score_nxt = score_r + SCORE_W'(prod) - tmp_r;
        default: ;
      endcase
    end
  end

  // Threshold compare and output saturation.
  always_comb begin
    rhs_prod  = RP_W'(thr_r) * RP_W'(THR_SCALE);
    lhs       = {score_r, 8'b0};
    score_ext = SAT_W'(score_r);
    score_sat = (score_ext > SAT_W'(wvsd_pkg::SCORE_OUT_MAX)) ?
                wvsd_pkg::SCORE_OUT_MAX : score_ext[wvsd_pkg::SCORE_OUT_W-1:0];
  end

  // Output stage valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;

  // Control state and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      valid_r     <= '0;
      thr_r       <= wvsd_pkg::THR_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NA; i++) begin
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
      end
    end else begin
      slot_r      <= slot_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tmp_r   <= tmp_nxt;
    score_r <= score_nxt;
    rhs_r   <= CMP_W'(rhs_prod);
    if (cmd.capture) begin
      new_r[0] <= sample_x;
      new_r[1] <= sample_y;
      new_r[2] <= sample_z;
    end
    if (cmd.load) begin
      old_r <= rd_old;
    end
    if (cmd.finish) begin
      out_stable_r <= (lhs < rhs_r);
      out_score_r  <= score_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_stable = out_stable_r;
  assign out_score     = out_score_r;

endmodule
